[design/i2cmbe_pkg.sv]
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// shared types and command codes of the i2c master bit engine
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

    localparam int BYTE_BITS = 8;
    localparam int CELL_W    = $clog2(BYTE_BITS + 1);

    // command codes
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_ACK   = 3'd2;
    localparam logic [2:0] OP_NACK  = 3'd3;
    localparam logic [2:0] OP_SEND  = 3'd4;
    localparam logic [2:0] OP_RECV  = 3'd5;

    // cell index of the acknowledge / settling cell after the eight data cells
    localparam logic [CELL_W-1:0] TAIL_CELL = CELL_W'(BYTE_BITS);

    typedef struct packed {
        logic [2:0]           operation;
        logic [BYTE_BITS-1:0] write_data;
        logic [BYTE_BITS-1:0] bus_read_bits;
        logic                 bus_ack_level;
    } t_cmd;

    typedef struct packed {
        logic                 scl_level;
        logic                 sda_level;
        logic                 sample_point;
        logic [BYTE_BITS-1:0] read_byte;
        logic                 ack_missing;
        logic                 last_phase;
    } t_phase;

    typedef struct packed {
        logic load;
        logic shift;
    } t_shift_ctrl;

endpackage

[design/i2cmbe_shift.sv]
// ----------------------------------------------------------------------------
// i2cmbe_shift
// byte shift unit, msb first, shared by every data cell of a send
// ----------------------------------------------------------------------------
module i2cmbe_shift (
    input  logic                           i_clk,
    input  i2cmbe_pkg::t_shift_ctrl        i_ctrl,
    input  logic [i2cmbe_pkg::BYTE_BITS-1:0] i_load_data,
    output logic                           o_msb
);
    import i2cmbe_pkg::*;

    logic [BYTE_BITS-1:0] r_shift;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_shift <= i_load_data;
        end else if (i_ctrl.shift) begin
            r_shift <= {r_shift[BYTE_BITS-2:0], 1'b0};
        end
    end

    assign o_msb = r_shift[BYTE_BITS-1];

endmodule

[design/i2c_master_bit_engine.sv]
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// open-drain i2c master: one command in, a run of scl/sda line phases out.
// a known command runs 2 to 27 phases, one phase per cycle while the output side
// takes them; the phase sequencer steps one cell counter and one shift unit.
// command accepted only when idle: a new command waits until the run's last phase.
// first phase is registered after the command transfer, once the run has started.
// sync active-low reset: idle, no phase pending, clock line released high.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  i2cmbe_pkg::t_cmd   i_cmd,
    // line phase channel
    output logic               o_phase_valid,
    input  logic               i_phase_ready,
    output i2cmbe_pkg::t_phase o_phase
);
    import i2cmbe_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state, n_state;

    // command held for the run
    logic [2:0]           r_op;
    logic [BYTE_BITS-1:0] r_rbits;
    logic                 r_ack;
    // sequencer position: cell and phase within the cell
    logic [CELL_W-1:0]    r_cell, n_cell;
    logic [1:0]           r_sub, n_sub;
    // clock line level left by the last phase
    logic                 r_clk, n_clk;
    // output register
    logic                 r_out_valid, n_out_valid;
    t_phase               r_out, n_out;

    t_shift_ctrl          shift_ctrl;
    logic                 msb;
    logic                 cmd_xfer;
    logic                 advance;
    logic                 cell_end;
    t_phase               phase;

    assign o_cmd_ready   = (r_state == ST_IDLE);
    assign cmd_xfer      = i_cmd_valid && o_cmd_ready;
    assign advance       = (r_state == ST_RUN) && (!r_out_valid || i_phase_ready);
    assign o_phase_valid = r_out_valid;
    assign o_phase       = r_out;

    // phase generator for the current cell position
    always_comb begin
        phase    = '0;
        cell_end = (r_sub == 2'd2);
        case (r_op)
            OP_START: begin
                phase.scl_level  = (r_sub != 2'd2);
                phase.sda_level  = (r_sub == 2'd0);
                phase.last_phase = (r_sub == 2'd2);
            end
            OP_STOP: begin
                cell_end         = (r_sub == 2'd1);
                phase.scl_level  = 1'b1;
                phase.sda_level  = (r_sub == 2'd1);
                phase.last_phase = (r_sub == 2'd1);
            end
            OP_ACK, OP_NACK: begin
                // data setup with clock unchanged, clock high, clock low
                phase.scl_level  = (r_sub == 2'd0) ? r_clk : (r_sub == 2'd1);
                phase.sda_level  = (r_op == OP_NACK);
                phase.last_phase = (r_sub == 2'd2);
            end
            OP_SEND: begin
                phase.scl_level    = (r_sub == 2'd0) ? r_clk : (r_sub == 2'd1);
                // tail cell releases sda for the slave acknowledge
                phase.sda_level    = (r_cell == TAIL_CELL) ? 1'b1 : msb;
                phase.sample_point = (r_cell == TAIL_CELL) && (r_sub == 2'd1);
                phase.last_phase   = (r_cell == TAIL_CELL) && (r_sub == 2'd2);
                phase.ack_missing  = phase.last_phase && r_ack;
            end
            OP_RECV: begin
                // two-phase cells, then a single settling phase
                cell_end           = (r_sub == 2'd1);
                phase.scl_level    = (r_sub == 2'd1);
                phase.sda_level    = 1'b1;
                phase.sample_point = (r_sub == 2'd1) && (r_cell != TAIL_CELL);
                phase.last_phase   = (r_cell == TAIL_CELL);
                phase.read_byte    = phase.last_phase ? r_rbits : '0;
            end
            default: begin
                phase.last_phase = 1'b1;
            end
        endcase
    end

    // shift unit control: load on command transfer, shift after each send data cell
    always_comb begin
        shift_ctrl.load  = cmd_xfer;
        shift_ctrl.shift = advance && (r_op == OP_SEND) && cell_end
                           && (r_cell != TAIL_CELL);
    end

    i2cmbe_shift u_shift (
        .i_clk       (i_clk),
        .i_ctrl      (shift_ctrl),
        .i_load_data (i_cmd.write_data),
        .o_msb       (msb)
    );

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_cell      = r_cell;
        n_sub       = r_sub;
        n_clk       = r_clk;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        // output slot drains on transfer
        if (r_out_valid && i_phase_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                // unknown codes are taken and dropped
                if (cmd_xfer && (i_cmd.operation inside {[OP_START:OP_RECV]})) begin
                    n_state = ST_RUN;
                    n_cell  = '0;
                    n_sub   = '0;
                end
            end
            ST_RUN: begin
                if (advance) begin
                    n_out       = phase;
                    n_out_valid = 1'b1;
                    n_clk       = phase.scl_level;
                    if (phase.last_phase) begin
                        n_state = ST_IDLE;
                    end else if (cell_end) begin
                        n_sub  = '0;
                        n_cell = r_cell + 1'b1;
                    end else begin
                        n_sub = r_sub + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cell      <= '0;
            r_sub       <= '0;
            r_clk       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cell      <= n_cell;
            r_sub       <= n_sub;
            r_clk       <= n_clk;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (cmd_xfer) begin
            r_op    <= i_cmd.operation;
            r_rbits <= i_cmd.bus_read_bits;
            r_ack   <= i_cmd.bus_ack_level;
        end
    end

endmodule
